// File: src/pdp_pkg.sv
// Shared types, constants and defaults for the peak detector and packetizer.
package pdp_pkg;

    localparam int WINDOW_DEPTH_DEF = 16;
    localparam int PACKET_MAX_DEF   = 32;

    localparam int SAMPLE_W   = 8;
    localparam int BYTE_W     = 8;
    localparam int GAP_W      = 8;
    localparam int LIMIT_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST  = 8'd120;
    localparam logic [GAP_W-1:0]    GAP_FIRST_RST  = 8'd48;
    localparam logic [GAP_W-1:0]    GAP_STEP_RST   = 8'd32;
    localparam logic [LIMIT_W-1:0]  MARKER_LIM_RST = 6'd10;

    localparam logic [BYTE_W-1:0] ZERO_MARKER = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PEAK_THRESHOLD = 2'd0,
        CFG_GAP_FIRST      = 2'd1,
        CFG_GAP_STEP       = 2'd2,
        CFG_MARKER_LIMIT   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHOW
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic take;   // accept the sample request on the input channel
        logic read;   // fetch the next packet byte from the store
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic close;  // the presented sample closes a non-empty packet
        logic last;   // the byte on display is the final one of the packet
    } status_t;

endpackage

// File: src/pdp_if.sv
// Channel interfaces: sample input, packet byte output and configuration writes.
interface pdp_in_if
    import pdp_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface pdp_out_if
    import pdp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] packet_byte;
    logic              last;

    modport source (output valid, output packet_byte, output last, input ready);
    modport sink   (input valid, input packet_byte, input last, output ready);
endinterface

interface pdp_cfg_if
    import pdp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/peak_detect_and_packetize_top.sv
// Top level of the sliding-window peak detector and packetizer.
//
// Samples enter on the samples channel and are taken one per cycle while no
// packet is draining. Each sample steps a window of WINDOW_DEPTH slots; the
// largest sample above peak_threshold becomes the candidate and is released as
// a peak when its slot comes around again. Peaks go into a packet store of
// PACKET_MAX bytes; gaps without peaks add zero markers (after gap_first
// peakless samples, then every gap_step more). A packet closes when the store
// is full or when marker_limit markers follow the last peak; trailing markers
// are dropped. Once the sample that closes a packet is taken, the packet
// leaves on the packets channel with last set on its final byte. The store
// is one RAM with a registered read port, so each byte is drained by a read
// state and then a show state, plus any output stall, and the samples
// channel holds ready low until the final byte is taken. The window keeps
// only the candidate's position and value, since the slot's content is never
// needed except as the released peak. Configuration writes are always
// accepted and should be made only while the block is idle.
module peak_detect_and_packetize_top
    import pdp_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int PACKET_MAX   = PACKET_MAX_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    pdp_in_if.sink    samples,
    pdp_out_if.source packets,
    pdp_cfg_if.sink   cfg
);

    cmd_t    cmd;
    status_t status;

    // configuration writes never stall
    assign cfg.ready = 1'b1;

    pdp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (packets.valid),
        .out_ready (packets.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // the RAM read register and the last flag form the output register
    pdp_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .PACKET_MAX   (PACKET_MAX)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample    (samples.sample),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_byte  (packets.packet_byte),
        .out_last  (packets.last)
    );

endmodule

// File: src/pdp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/pdp_ctrl.sv
// Sequencer: takes samples, then drains a closed packet byte by byte.
module pdp_ctrl
    import pdp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
                if (in_valid && status.close)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = status.last ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/pdp_datapath.sv
// Window tracking, gap counting, packet store and readout registers.
module pdp_datapath
    import pdp_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int PACKET_MAX   = PACKET_MAX_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic [SAMPLE_W-1:0]   sample,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [BYTE_W-1:0]     out_byte,
    output logic                  out_last
);

    localparam int RP_W  = $clog2(WINDOW_DEPTH);
    localparam int AW    = $clog2(PACKET_MAX);
    localparam int CW    = $clog2(PACKET_MAX + 1);
    localparam int CMP_W = (CW > LIMIT_W) ? CW : LIMIT_W;

    // configuration
    logic [SAMPLE_W-1:0] threshold_reg;
    logic [GAP_W-1:0]    gap_first_reg;
    logic [GAP_W-1:0]    gap_step_reg;
    logic [LIMIT_W-1:0]  marker_limit_reg;

    // window state; the candidate value mirrors its ring slot
    logic [RP_W-1:0]     ring_pos_reg;
    logic                cand_valid_reg;
    logic [RP_W-1:0]     cand_pos_reg;
    logic [SAMPLE_W-1:0] cand_val_reg;

    // packet state
    logic [CW-1:0]       fill_reg;
    logic [GAP_W-1:0]    gap_reg;
    logic [CW-1:0]       marker_reg;
    logic [CW-1:0]       emit_len_reg;
    logic [CW-1:0]       rd_addr_reg;
    logic                last_reg;

    logic                released;
    logic                cand_kept;
    logic                new_cand;
    logic [RP_W-1:0]     ring_pos_next;
    logic                cand_valid_next;
    logic [CW-1:0]       fill_next;
    logic [GAP_W-1:0]    gap_next;
    logic [CW-1:0]       marker_next;
    logic                close_any;
    logic [CW-1:0]       close_len;
    logic                st_we;
    logic [BYTE_W-1:0]   st_wdata;
    logic [GAP_W-1:0]    gap_inc;
    logic [CW-1:0]       fill_inc;
    logic [CW-1:0]       marker_inc;
    logic [CW-1:0]       rd_addr_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESHOLD_RST;
            gap_first_reg    <= GAP_FIRST_RST;
            gap_step_reg     <= GAP_STEP_RST;
            marker_limit_reg <= MARKER_LIM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PEAK_THRESHOLD: threshold_reg    <= cfg_data;
                CFG_GAP_FIRST:      gap_first_reg    <= cfg_data;
                CFG_GAP_STEP:       gap_step_reg     <= cfg_data;
                CFG_MARKER_LIMIT:   marker_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:            ;
            endcase
        end
    end

    // window stage
    always_comb
    begin
        released  = cand_valid_reg && (cand_pos_reg == ring_pos_reg);
        cand_kept = cand_valid_reg && !released;
        new_cand  = cand_kept ? (sample > cand_val_reg) : (sample > threshold_reg);
        cand_valid_next = cand_kept || new_cand;
        ring_pos_next   = (ring_pos_reg == RP_W'(WINDOW_DEPTH - 1)) ? '0 : ring_pos_reg + 1'b1;
    end

    // packet stage
    always_comb
    begin
        gap_inc    = gap_reg + 1'b1;
        fill_inc   = fill_reg + 1'b1;
        marker_inc = marker_reg + 1'b1;
        fill_next   = fill_reg;
        gap_next    = gap_reg;
        marker_next = marker_reg;
        close_any   = 1'b0;
        close_len   = '0;
        st_we       = 1'b0;
        st_wdata    = cand_val_reg;
        if (released)
        begin
            st_we       = 1'b1;
            fill_next   = fill_inc;
            gap_next    = '0;
            marker_next = '0;
            if (fill_inc == CW'(PACKET_MAX))
            begin
                close_any = 1'b1;
                close_len = fill_inc;
                fill_next = '0;
            end
        end
        else if (fill_reg != '0)
        begin
            gap_next = gap_inc;
            if (gap_inc >= gap_first_reg)
            begin
                st_we       = 1'b1;
                st_wdata    = ZERO_MARKER;
                fill_next   = fill_inc;
                gap_next    = gap_inc - gap_step_reg;
                marker_next = marker_inc;
                if ((CMP_W'(marker_inc) == CMP_W'(marker_limit_reg)) ||
                    (fill_inc == CW'(PACKET_MAX)))
                begin
                    // drop the trailing markers
                    close_any   = 1'b1;
                    close_len   = fill_inc - marker_inc;
                    fill_next   = '0;
                    gap_next    = '0;
                    marker_next = '0;
                end
            end
        end
    end

    assign status.close = close_any && (close_len != '0);
    assign status.last  = last_reg;
    assign rd_addr_inc  = rd_addr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_pos_reg   <= '0;
            cand_valid_reg <= 1'b0;
            cand_pos_reg   <= '0;
            fill_reg       <= '0;
            gap_reg        <= '0;
            marker_reg     <= '0;
            emit_len_reg   <= '0;
            rd_addr_reg    <= '0;
        end
        else
        begin
            if (cmd.take)
            begin
                ring_pos_reg   <= ring_pos_next;
                cand_valid_reg <= cand_valid_next;
                if (new_cand)
                begin
                    cand_pos_reg <= ring_pos_reg;
                end
                fill_reg   <= fill_next;
                gap_reg    <= gap_next;
                marker_reg <= marker_next;
                if (status.close)
                begin
                    emit_len_reg <= close_len;
                    rd_addr_reg  <= '0;
                end
            end
            else if (cmd.read)
            begin
                rd_addr_reg <= rd_addr_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && new_cand)
        begin
            cand_val_reg <= sample;
        end
        if (cmd.read)
        begin
            last_reg <= (rd_addr_inc == emit_len_reg);
        end
    end

    pdp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PACKET_MAX)
    ) u_store (
        .clk   (clk),
        .we    (cmd.take && st_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (st_wdata),
        .re    (cmd.read),
        .raddr (rd_addr_reg[AW-1:0]),
        .rdata (out_byte)
    );

    assign out_last = last_reg;

endmodule

// File: tb/peak_detect_and_packetize_top_tb.sv
// Self-checking testbench for the peak detector and packetizer top level.
`timescale 1ns / 1ps

module peak_detect_and_packetize_top_tb;
    import pdp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;  // far beyond the slowest legal run
    localparam int SETTLE       = 16;      // quiet cycles before a register write
    localparam int HOLD_CYCLES  = 300;     // long receiver hold-off

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              last;
    } pkt_byte_t;

    logic clk = 1'b0;
    logic rst_n;

    pdp_in_if  samples_ch ();
    pdp_out_if packets_ch ();
    pdp_cfg_if cfg_ch ();

    peak_detect_and_packetize_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .packets (packets_ch),
        .cfg     (cfg_ch)
    );

    always #5 clk = ~clk;

    // Sample requests waiting to be offered, and packet bytes still owed by the block.
    logic [SAMPLE_W-1:0] pending_samples [$];
    pkt_byte_t           expected_bytes [$];

    int  samples_queued   = 0;
    int  samples_accepted = 0;
    int  bytes_checked    = 0;
    int  packets_checked  = 0;
    int  error_count      = 0;
    int  cycle_count      = 0;
    int  send_idle_pct    = 0;
    int  recv_idle_pct    = 0;
    bit  sample_took      = 1'b0;
    bit  hold_go          = 1'b0;
    logic rx_hold         = 1'b0;

    // ------------------------------------------------------------------
    // Shadow of the block: window, candidate, packet store and counters.
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] win [WINDOW_DEPTH_DEF];
    logic [3:0]          win_pos     = '0;
    bit                  peak_armed  = 1'b0;
    logic [3:0]          peak_slot   = '0;
    logic [BYTE_W-1:0]   pkt_store [PACKET_MAX_DEF];
    int                  pkt_fill    = 0;
    logic [GAP_W-1:0]    gap_cnt     = '0;
    int                  mark_cnt    = 0;

    // Shadow registers, reset values as in the block.
    logic [SAMPLE_W-1:0] m_thr       = THRESHOLD_RST;
    logic [GAP_W-1:0]    m_gap_first = GAP_FIRST_RST;
    logic [GAP_W-1:0]    m_gap_step  = GAP_STEP_RST;
    logic [LIMIT_W-1:0]  m_mark_lim  = MARKER_LIM_RST;

    // Advance the shadow by one accepted sample and queue any packet it closes.
    task automatic predict_sample(input logic [SAMPLE_W-1:0] s);
        bit                released;
        logic [BYTE_W-1:0] peak;
        int                close_len;
        pkt_byte_t         pb;
        released  = 1'b0;
        peak      = '0;
        close_len = 0;

        // Release the candidate when its slot is about to be overwritten.
        if (peak_armed && peak_slot == win_pos) begin
            released   = 1'b1;
            peak       = win[win_pos];
            peak_armed = 1'b0;
        end
        win[win_pos] = s;
        // A live candidate is displaced only by a strictly larger sample.
        if (peak_armed ? (s > win[peak_slot]) : (s > m_thr)) begin
            peak_armed = 1'b1;
            peak_slot  = win_pos;
        end
        win_pos = win_pos + 4'd1;  // wraps with the 16-slot window

        if (released) begin
            if (pkt_fill < PACKET_MAX_DEF) begin
                pkt_store[pkt_fill] = peak;
                pkt_fill++;
            end
            gap_cnt  = '0;
            mark_cnt = 0;
            if (pkt_fill >= PACKET_MAX_DEF) begin
                close_len = pkt_fill;
                pkt_fill  = 0;
            end
        end else if (pkt_fill > 0) begin
            // Gap counter is 8 bits: both the step up and the subtraction wrap.
            gap_cnt = gap_cnt + 8'd1;
            if (gap_cnt >= m_gap_first) begin
                if (pkt_fill < PACKET_MAX_DEF) begin
                    pkt_store[pkt_fill] = ZERO_MARKER;
                    pkt_fill++;
                end
                gap_cnt = gap_cnt - m_gap_step;
                mark_cnt++;
                // Close on the marker limit or on a full store; drop trailing markers.
                if (mark_cnt == int'(m_mark_lim) || pkt_fill >= PACKET_MAX_DEF) begin
                    close_len = (pkt_fill > mark_cnt) ? pkt_fill - mark_cnt : 0;
                    pkt_fill  = 0;
                    gap_cnt   = '0;
                    mark_cnt  = 0;
                end
            end
        end

        for (int k = 0; k < close_len; k++) begin
            pb.value = pkt_store[k];
            pb.last  = (k == close_len - 1);
            expected_bytes.push_back(pb);
        end
    endtask

    // ------------------------------------------------------------------
    // Sample driver: change inputs on the falling edge only.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n && (!samples_ch.valid || sample_took)) begin
            // Offer the next request unless this cycle is an idle one.
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                samples_ch.valid  <= 1'b1;
                samples_ch.sample <= pending_samples.pop_front();
            end else begin
                samples_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random, and hold off entirely while rx_hold is up.
    always @(negedge clk) begin
        packets_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Long hold-off, counted here so the driver keeps offering samples meanwhile.
    initial begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: sample on the rising edge; predict first, then check output.
    // ------------------------------------------------------------------
    pkt_byte_t oldest;

    always @(posedge clk) begin
        if (!rst_n) begin
            sample_took = 1'b0;
        end else begin
            sample_took = samples_ch.valid && samples_ch.ready;
            if (sample_took) begin
                predict_sample(samples_ch.sample);
                samples_accepted++;
            end
            if (packets_ch.valid && packets_ch.ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected packet byte: got %0d last %0b",
                           packets_ch.packet_byte, packets_ch.last);
                    error_count++;
                end else begin
                    oldest = expected_bytes.pop_front();
                    if (packets_ch.packet_byte !== oldest.value) begin
                        $error("packet_byte mismatch: expected %0d, got %0d",
                               oldest.value, packets_ch.packet_byte);
                        error_count++;
                    end
                    if (packets_ch.last !== oldest.last) begin
                        $error("last mismatch: expected %0b, got %0b",
                               oldest.last, packets_ch.last);
                        error_count++;
                    end
                end
                bytes_checked++;
                if (packets_ch.last === 1'b1)
                    packets_checked++;
            end
        end
    end

    // Stop a hung run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_sample(input logic [SAMPLE_W-1:0] s);
        pending_samples.push_back(s);
        samples_queued++;
    endtask

    // Mostly well-formed shapes: a spike over the threshold followed by a quiet
    // run that lets the peak come around and the gap counter work; the rest is
    // noise and repeated values that must not displace an equal candidate.
    task automatic queue_random(input int count);
        int                  left;
        int                  run;
        logic [SAMPLE_W-1:0] hi;
        left = count;
        while (left > 0) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: begin
                    hi = (m_thr == 8'd255) ? 8'd255
                                           : 8'($urandom_range(255, int'(m_thr) + 1));
                    queue_sample(hi);
                    left--;
                    run = $urandom_range(20, 1);
                    while (run > 0 && left > 0) begin
                        queue_sample(8'($urandom_range(int'(m_thr))));
                        run--;
                        left--;
                    end
                end
                6, 7, 8: begin
                    queue_sample(8'($urandom_range(255)));
                    left--;
                end
                default: begin
                    hi = 8'($urandom_range(255));
                    queue_sample(hi);
                    queue_sample(hi);
                    left -= 2;
                end
            endcase
        end
    endtask

    // Wait until every request is taken and every packet byte seen, then let
    // the block settle so a register write finds it idle.
    task automatic wait_idle();
        while (samples_accepted != samples_queued || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // One register write on the configuration channel; mirror it in the shadow.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            CFG_PEAK_THRESHOLD: m_thr       = value;
            CFG_GAP_FIRST:      m_gap_first = value;
            CFG_GAP_STEP:       m_gap_step  = value;
            CFG_MARKER_LIMIT:   m_mark_lim  = value[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Reprogram all four registers, set the idle mix, run a random batch.
    task automatic run_setting(input logic [7:0] thr, input logic [7:0] first,
                               input logic [7:0] step, input logic [7:0] limit,
                               input int send_pct, input int recv_pct, input int count);
        write_reg(CFG_PEAK_THRESHOLD, thr);
        write_reg(CFG_GAP_FIRST, first);
        write_reg(CFG_GAP_STEP, step);
        write_reg(CFG_MARKER_LIMIT, limit);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        queue_random(count);
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n              = 1'b0;
        samples_ch.valid   = 1'b0;
        samples_ch.sample  = '0;
        packets_ch.ready   = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_PEAK_THRESHOLD;
        cfg_ch.data        = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings, sender idles lightly and receiver heavily.
        send_idle_pct = 24;
        recv_idle_pct = 75;

        // Directed: sample extremes, a sample equal to the threshold, an equal
        // value that must not replace the candidate, then a full window turn so
        // the first peak is released and opens a packet, and a strictly larger
        // sample that moves the new candidate.
        queue_sample(8'd0);   queue_sample(8'd255); queue_sample(8'd120);
        queue_sample(8'd255); queue_sample(8'd121); queue_sample(8'd0);
        queue_sample(8'd254); queue_sample(8'd1);   queue_sample(8'd2);
        queue_sample(8'd3);   queue_sample(8'd4);   queue_sample(8'd5);
        queue_sample(8'd6);   queue_sample(8'd7);   queue_sample(8'd8);
        queue_sample(8'd9);   queue_sample(8'd200); queue_sample(8'd130);
        queue_sample(8'd121); queue_sample(8'd119); queue_sample(8'd0);
        queue_sample(8'd128); queue_sample(8'd64);  queue_sample(8'd255);
        queue_sample(8'd1);
        queue_random(20);
        wait_idle();

        // Step above first, so the gap count wraps; marker limit equal to the store depth.
        run_setting(8'd30, 8'd1, 8'd255, 8'd32, 24, 75, 35);

        // Swap the idle mix. Zero threshold with short gaps: many small packets.
        run_setting(8'd0, 8'd4, 8'd2, 8'd1 + 8'd2, 75, 24, 35);

        // Top threshold (no new candidates) and zero gap_first: every peakless
        // sample in an open packet stores a marker; one marker closes it.
        run_setting(8'd255, 8'd0, 8'd255, 8'd1, 75, 24, 10);

        // Marker limit zero: the packet closes only once the store is full.
        run_setting(8'd90, 8'd1, 8'd1, 8'd0, 75, 24, 45);

        // Largest gap settings and an unreachable marker limit; no idling.
        run_setting(8'd200, 8'd255, 8'd255, 8'd63, 0, 0, 15);

        // No idling, but hold the receiver off long enough that a packet backs
        // up and the block stops taking samples.
        hold_go = 1'b1;
        run_setting(8'd60, 8'd2, 8'd1, 8'd2, 0, 0, 40);

        $display("Covered %0d samples over seven register settings, three idle mixes",
                 samples_accepted);
        $display("and a long output stall; checked %0d bytes in %0d packets.",
                 bytes_checked, packets_checked);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
